[design/plc_pkg.sv]
`timescale 1ns / 1ps
// plc_pkg: shared widths, codes and sideband type for the piecewise-linear
// calibration pipeline; no dependencies
package plc_pkg;

	localparam int NUM_RANGES_DEF = 6;
	localparam int NUM_POINTS_DEF = 7;

	// field widths
	localparam int PT_RD_W  = 16;  // breakpoint reading, integer counts
	localparam int RD_W     = 24;  // reading, Q16.8
	localparam int VAL_W    = 32;  // value, Q20.12
	localparam int FRAC_W   = RD_W - PT_RD_W;

	// datapath widths
	localparam int DEN_W    = RD_W;            // |reading difference|
	localparam int PROD_W   = RD_W + VAL_W;    // |dividend|
	localparam int SUM_W    = PROD_W + 2;      // signed sum
	localparam int DIV_STEP = 4;               // quotient bits per divider stage
	localparam int DIV_STAGES = PROD_W / DIV_STEP;

	localparam logic [VAL_W-1:0] MIN_VAL = VAL_W'(4);  // 0.001 in Q20.12
	localparam logic [VAL_W-1:0] MAX_VAL = '1;

	// operations
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	// register map, index taken from paddr[2]
	localparam logic REG_CAL_VALID = 1'b0;

	typedef struct packed {
		logic             force_zero;  // uncalibrated or bad bank
		logic             neg;         // quotient is negative
		logic             den_zero;    // equal breakpoint readings
		logic [VAL_W-1:0] lv;          // lower breakpoint value
	} side_t;

endpackage

[design/plc_table.sv]
`timescale 1ns / 1ps
// plc_table: breakpoint store, one row of readings and values per bank,
// written one point at a time, read a whole row; uses plc_pkg
module plc_table import plc_pkg::*; #(
	parameter int NUM_RANGES = NUM_RANGES_DEF,
	parameter int NUM_POINTS = NUM_POINTS_DEF,
	localparam int BANK_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1,
	localparam int PT_W   = $clog2(NUM_POINTS)
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [BANK_W-1:0]                    wr_bank,
	input  logic [PT_W-1:0]                      wr_pt,
	input  logic [PT_RD_W-1:0]                   wr_rd,
	input  logic [VAL_W-1:0]                     wr_val,
	input  logic                                 rd_en,
	input  logic [BANK_W-1:0]                    rd_bank,
	output logic [NUM_POINTS-1:0][PT_RD_W-1:0]   rd_row_s1,
	output logic [NUM_POINTS-1:0][VAL_W-1:0]     val_row_s1
);

	logic [NUM_POINTS-1:0][PT_RD_W-1:0] rd_mem  [NUM_RANGES];
	logic [NUM_POINTS-1:0][VAL_W-1:0]   val_mem [NUM_RANGES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_mem[wr_bank][wr_pt]  <= wr_rd;
			val_mem[wr_bank][wr_pt] <= wr_val;
		end
		if (rd_en) begin
			rd_row_s1  <= rd_mem[rd_bank];
			val_row_s1 <= val_mem[rd_bank];
		end
	end

endmodule

[design/plc_seg.sv]
`timescale 1ns / 1ps
// plc_seg: segment choice, then breakpoint select and the three differences
// as sign and magnitude; two pipeline stages; uses plc_pkg
module plc_seg import plc_pkg::*; #(
	parameter int NUM_POINTS = NUM_POINTS_DEF,
	localparam int PT_W = $clog2(NUM_POINTS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                vld_s1,
	input  logic [RD_W-1:0]                     v_s1,
	input  logic                                fz_s1,
	input  logic [NUM_POINTS-1:0][PT_RD_W-1:0]  rd_row_s1,
	input  logic [NUM_POINTS-1:0][VAL_W-1:0]    val_row_s1,
	output logic                                vld_s3,
	output logic [DEN_W-1:0]                    a_mag_s3,
	output logic [VAL_W-1:0]                    b_mag_s3,
	output logic [DEN_W-1:0]                    d_mag_s3,
	output side_t                               side_s3
);

	logic [NUM_POINTS-2:0] below;
	logic                  upper0;
	logic [PT_W-1:0]       seg_n;

	logic                               vld_s2;
	logic [PT_W-1:0]                    seg_s2;
	logic [RD_W-1:0]                    v_s2;
	logic                               fz_s2;
	logic [NUM_POINTS-1:0][PT_RD_W-1:0] rd_row_s2;
	logic [NUM_POINTS-1:0][VAL_W-1:0]   val_row_s2;

	// lower breakpoint of segment s lies below the reading
	always_comb begin
		for (int s = 0; s < NUM_POINTS - 1; s++) begin
			below[s] = v_s1 > {rd_row_s1[s+1], FRAC_W'(0)};
		end
		upper0 = {rd_row_s1[0], FRAC_W'(0)} >= v_s1;
	end

	always_comb begin
		seg_n = PT_W'(NUM_POINTS - 2);
		for (int s = NUM_POINTS - 3; s >= 1; s--) begin
			if (below[s]) seg_n = PT_W'(s);
		end
		if (upper0 && below[0]) seg_n = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s2     <= seg_n;
			v_s2       <= v_s1;
			fz_s2      <= fz_s1;
			rd_row_s2  <= rd_row_s1;
			val_row_s2 <= val_row_s1;
		end
	end

	logic [PT_W-1:0]   seg_lo;
	logic [RD_W:0]     hr, lr, a_dif, d_dif;
	logic [VAL_W:0]    hv, lv, b_dif;
	logic [DEN_W-1:0]  a_mag, d_mag;
	logic [VAL_W-1:0]  b_mag;

	always_comb begin
		seg_lo = seg_s2 + PT_W'(1);
		hr     = {1'b0, rd_row_s2[seg_s2], FRAC_W'(0)};
		lr     = {1'b0, rd_row_s2[seg_lo], FRAC_W'(0)};
		hv     = {1'b0, val_row_s2[seg_s2]};
		lv     = {1'b0, val_row_s2[seg_lo]};
		a_dif  = {1'b0, v_s2} - lr;
		d_dif  = hr - lr;
		b_dif  = hv - lv;
		a_mag  = a_dif[RD_W] ? DEN_W'(-a_dif) : a_dif[DEN_W-1:0];
		d_mag  = d_dif[RD_W] ? DEN_W'(-d_dif) : d_dif[DEN_W-1:0];
		b_mag  = b_dif[VAL_W] ? VAL_W'(-b_dif) : b_dif[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_mag_s3           <= a_mag;
			b_mag_s3           <= b_mag;
			d_mag_s3           <= d_mag;
			side_s3.force_zero <= fz_s2;
			side_s3.neg        <= a_dif[RD_W] ^ b_dif[VAL_W] ^ d_dif[RD_W];
			side_s3.den_zero   <= (d_dif == '0);
			side_s3.lv         <= lv[VAL_W-1:0];
		end
	end

endmodule

[design/plc_div.sv]
`timescale 1ns / 1ps
// plc_div: pipelined restoring divider for magnitudes, DIV_STEP quotient
// bits per stage; sideband travels alongside; uses plc_pkg
module plc_div import plc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld_in,
	input  logic [PROD_W-1:0] dvd_in,
	input  logic [DEN_W-1:0]  dsr_in,
	input  side_t             side_in,
	output logic              vld_out,
	output logic [PROD_W-1:0] quo_out,
	output side_t             side_out
);

	// per stage: dq holds dividend bits not yet used on top, quotient below
	logic                vld_s  [DIV_STAGES+1];
	logic [PROD_W-1:0]   dq_s   [DIV_STAGES+1];
	logic [DEN_W-1:0]    rem_s  [DIV_STAGES+1];
	logic [DEN_W-1:0]    dsr_s  [DIV_STAGES+1];
	side_t               side_s [DIV_STAGES+1];

	assign vld_s[0]  = vld_in;
	assign dq_s[0]   = dvd_in;
	assign rem_s[0]  = '0;
	assign dsr_s[0]  = dsr_in;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [PROD_W-1:0] dq_n;
		logic [DEN_W-1:0]  rem_n;

		always_comb begin
			logic [DEN_W:0] t;
			logic           ge;
			dq_n  = dq_s[k];
			rem_n = rem_s[k];
			for (int i = 0; i < DIV_STEP; i++) begin
				t     = {rem_n, dq_n[PROD_W-1]};
				ge    = t >= {1'b0, dsr_s[k]};
				dq_n  = {dq_n[PROD_W-2:0], ge};
				rem_n = ge ? DEN_W'(t - {1'b0, dsr_s[k]}) : t[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dq_s[k+1]   <= dq_n;
				rem_s[k+1]  <= rem_n;
				dsr_s[k+1]  <= dsr_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_out  = vld_s[DIV_STAGES];
	assign quo_out  = dq_s[DIV_STAGES];
	assign side_out = side_s[DIV_STAGES];

endmodule

[design/piecewise_linear_calibration_top.sv]
`timescale 1ns / 1ps
// piecewise_linear_calibration_top: calibration pipeline top level, config
// register, multiply and final clamp; uses plc_pkg, plc_table, plc_seg, plc_div
//
// Usage
//   Input channel (in_valid / in_stall) carries one beat per item. op selects
//   a load (write one breakpoint of bank range_sel at point_index) or a
//   convert (interpolate reading along the chosen segment of bank range_sel).
//   Loads give no result beat; each convert gives exactly one on the output
//   channel (out_valid / out_stall): value_out in Q20.12 and clamped.
//   Pipeline: a convert passes the table read, segment pick, select, multiply,
//   14 divider stages of four quotient bits each, clamp and output register.
//   Throughput: one beat per cycle on either channel while no result is held
//   by out_stall; the pipeline depth of the divider sets the latency, the
//   single output register sets the rate.
//   When the receiver stalls while a result waits, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing moves until it drops.
//   Reset (arst_n low) clears all valid bits and cal_valid; the breakpoint
//   store holds no defined content until loaded. cal_valid sits at APB byte
//   address 0, to be written only while idle; the block does not enforce it.
module piecewise_linear_calibration_top import plc_pkg::*; #(
	parameter int NUM_RANGES = NUM_RANGES_DEF,
	parameter int NUM_POINTS = NUM_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [2:0]          range_sel,
	input  logic [2:0]          point_index,
	input  logic [PT_RD_W-1:0]  point_reading,
	input  logic [VAL_W-1:0]    point_value,
	input  logic [RD_W-1:0]     reading,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [VAL_W-1:0]    value_out,
	output logic                clamped
);

	localparam int BANK_W = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
	localparam int PT_W   = $clog2(NUM_POINTS);

	// ---------------- config register ----------------
	logic cal_valid_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_valid_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == REG_CAL_VALID) begin
			cal_valid_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_CAL_VALID) ? {31'b0, cal_valid_q} : '0;

	// ---------------- flow control ----------------
	// single global advance: the pipeline moves unless a result is stuck
	logic adv;
	logic out_valid_q;
	logic in_acc;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	// ---------------- stage 1: table access ----------------
	logic bank_ok, pt_ok;
	logic tbl_wr, tbl_rd;
	logic [NUM_POINTS-1:0][PT_RD_W-1:0] rd_row_s1;
	logic [NUM_POINTS-1:0][VAL_W-1:0]   val_row_s1;
	logic              vld_s1;
	logic [RD_W-1:0]   v_s1;
	logic              fz_s1;

	assign bank_ok = int'(range_sel) < NUM_RANGES;
	assign pt_ok   = int'(point_index) < NUM_POINTS;
	assign tbl_wr  = in_acc && op == OP_LOAD && bank_ok && pt_ok;
	assign tbl_rd  = in_acc && op == OP_CONVERT && bank_ok;

	plc_table #(
		.NUM_RANGES (NUM_RANGES),
		.NUM_POINTS (NUM_POINTS)
	) u_table (
		.clk        (clk),
		.wr_en      (tbl_wr),
		.wr_bank    (BANK_W'(range_sel)),
		.wr_pt      (PT_W'(point_index)),
		.wr_rd      (point_reading),
		.wr_val     (point_value),
		.rd_en      (tbl_rd),
		.rd_bank    (BANK_W'(range_sel)),
		.rd_row_s1  (rd_row_s1),
		.val_row_s1 (val_row_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_acc && op == OP_CONVERT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1  <= reading;
			fz_s1 <= !(cal_valid_q && bank_ok);
		end
	end

	// ---------------- stages 2-3: segment pick and differences ----------------
	logic              vld_s3;
	logic [DEN_W-1:0]  a_mag_s3, d_mag_s3;
	logic [VAL_W-1:0]  b_mag_s3;
	side_t             side_s3;

	plc_seg #(
		.NUM_POINTS (NUM_POINTS)
	) u_seg (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.vld_s1     (vld_s1),
		.v_s1       (v_s1),
		.fz_s1      (fz_s1),
		.rd_row_s1  (rd_row_s1),
		.val_row_s1 (val_row_s1),
		.vld_s3     (vld_s3),
		.a_mag_s3   (a_mag_s3),
		.b_mag_s3   (b_mag_s3),
		.d_mag_s3   (d_mag_s3),
		.side_s3    (side_s3)
	);

	// ---------------- stage 4: magnitude product ----------------
	logic              vld_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [DEN_W-1:0]  d_mag_s4;
	side_t             side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4  <= PROD_W'(a_mag_s3) * PROD_W'(b_mag_s3);
			d_mag_s4 <= d_mag_s3;
			side_s4  <= side_s3;
		end
	end

	// ---------------- divider ----------------
	logic              div_vld;
	logic [PROD_W-1:0] div_quo;
	side_t             div_side;

	plc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_in   (vld_s4),
		.dvd_in   (prod_s4),
		.dsr_in   (d_mag_s4),
		.side_in  (side_s4),
		.vld_out  (div_vld),
		.quo_out  (div_quo),
		.side_out (div_side)
	);

	// ---------------- final add, clamp, output register ----------------
	logic [SUM_W-1:0] q_ext, q_sgn, sum;
	logic [VAL_W-1:0] res_val;
	logic             res_clamp;

	always_comb begin
		q_ext = div_side.den_zero ? '0 : {2'b0, div_quo};
		q_sgn = div_side.neg ? -q_ext : q_ext;
		sum   = q_sgn + {(SUM_W - VAL_W)'(0), div_side.lv};
		if (div_side.force_zero) begin
			res_val   = '0;
			res_clamp = 1'b0;
		end else if (sum[SUM_W-1] || sum[VAL_W-1:0] < MIN_VAL && sum[SUM_W-2:VAL_W] == '0) begin
			// negative or below the floor
			res_val   = MIN_VAL;
			res_clamp = 1'b1;
		end else if (sum[SUM_W-2:VAL_W] != '0) begin
			// beyond the full scale of the output
			res_val   = MAX_VAL;
			res_clamp = 1'b1;
		end else begin
			res_val   = sum[VAL_W-1:0];
			res_clamp = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && div_vld) begin
			value_out <= res_val;
			clamped   <= res_clamp;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	// a clamped result sits at the floor or at full scale
	a_clamp_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> value_out == MIN_VAL || value_out == MAX_VAL)
		else $error("clamped result off the limits");

	// a zero result only comes from the forced-zero path (uncalibrated or bad bank), never clamped
	a_zero_unclamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_out == '0 |-> !clamped)
		else $error("zero result marked clamped");

	// with no result waiting the pipeline never holds the input back
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// a held result stays put for the next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(clamped))
		else $error("stalled result changed");
`endif

endmodule
